/* src/psfs_pkg.sv */
// shared types, constants and the format decision function for the format sniffer
package psfs_pkg;

	localparam int unsigned SCAN_LIMIT = 8192;
	localparam int unsigned CNT_W      = $clog2(SCAN_LIMIT + 1);
	localparam int unsigned WIN_LEN    = 44;
	localparam int unsigned HDR_LEN    = 9;
	localparam int unsigned HDR_IDX_W  = $clog2(HDR_LEN);

	typedef enum logic [2:0] {
		FMT_UNKNOWN = 3'd0,
		FMT_XPS     = 3'd1,
		FMT_PCL     = 3'd2,
		FMT_EMF     = 3'd3,
		FMT_PS      = 3'd4,
		FMT_RAW     = 3'd5
	} fmt_t;

	typedef logic [HDR_LEN-1:0][7:0] hdr_t;

	// escape, "%-12345X"; index 0 is the first byte
	localparam hdr_t PJL_HDR = {8'h58, 8'h35, 8'h34, 8'h33, 8'h32,
		8'h31, 8'h2D, 8'h25, 8'h1B};

	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam int unsigned EMF_LOOKBACK = 40;

	// scan state after the current byte is taken in
	typedef struct packed {
		logic [CNT_W-1:0] count;
		hdr_t             hdr;
		logic             emf_seen;
		logic             ps_seen;
		logic             esc_seen;
	} scan_status_t;

	function automatic fmt_t decide_fmt(input scan_status_t st);
		fmt_t f;
		f = FMT_RAW;
		if (st.count < CNT_W'(4))
			f = FMT_UNKNOWN;
		else if (st.hdr[0] == 8'h50 && st.hdr[1] == 8'h4B &&
				st.hdr[2] == 8'h03 && st.hdr[3] == 8'h04)
			f = FMT_XPS;
		else if (st.hdr[0] == 8'h21 && st.hdr[1] == 8'h52 && st.hdr[2] == 8'h21)
			f = FMT_PCL;
		else if (st.count >= CNT_W'(HDR_LEN) && st.hdr == PJL_HDR)
			f = FMT_PCL;
		else if (st.emf_seen)
			f = FMT_EMF;
		else if (st.ps_seen)
			f = FMT_PS;
		else if (st.esc_seen)
			f = FMT_PCL;
		return f;
	endfunction

endpackage

/* src/psfs_scan.sv */
// scan state: byte count, header capture, sliding window and pattern flags
module psfs_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 is_last,
	output psfs_pkg::scan_status_t status
);
	import psfs_pkg::*;

	logic [CNT_W-1:0]            count_q;
	logic                        emf_q, ps_q, esc_q;
	hdr_t                        hdr_q, hdr_n;
	logic [WIN_LEN-1:0][7:0]     win_q, win_n;
	logic                        scan;
	logic                        emf_hit, ps_hit, esc_hit;

	assign scan = count_q < CNT_W'(SCAN_LIMIT);

	always_comb begin
		win_n = win_q;
		hdr_n = hdr_q;
		if (scan) begin
			win_n[WIN_LEN-2:0] = win_q[WIN_LEN-1:1];
			win_n[WIN_LEN-1]   = data_byte;
			if (count_q < CNT_W'(HDR_LEN))
				hdr_n[count_q[HDR_IDX_W-1:0]] = data_byte;
		end
	end

	// window index WIN_LEN-1 holds the current byte
	assign emf_hit = count_q >= CNT_W'(WIN_LEN - 1) &&
		win_n[40] == 8'h20 && win_n[41] == 8'h45 &&
		win_n[42] == 8'h4D && win_n[43] == 8'h46 &&
		win_n[43-EMF_LOOKBACK-3] == 8'h01 && win_n[43-EMF_LOOKBACK-2] == 8'h00 &&
		win_n[43-EMF_LOOKBACK-1] == 8'h00 && win_n[43-EMF_LOOKBACK] == 8'h00;
	assign ps_hit = count_q >= CNT_W'(3) &&
		win_n[40] == 8'h25 && win_n[41] == 8'h21 &&
		win_n[42] == 8'h50 && win_n[43] == 8'h53;
	assign esc_hit = count_q >= CNT_W'(1) && win_n[42] == ESC_BYTE &&
		(win_n[43] == 8'h45 || win_n[43] == 8'h26 || win_n[43] == 8'h2A);

	always_comb begin
		status.count    = scan ? count_q + CNT_W'(1) : count_q;
		status.hdr      = hdr_n;
		status.emf_seen = emf_q | (scan & emf_hit);
		status.ps_seen  = ps_q | (scan & ps_hit);
		status.esc_seen = esc_q | (scan & esc_hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			emf_q   <= 1'b0;
			ps_q    <= 1'b0;
			esc_q   <= 1'b0;
		end else if (step) begin
			if (is_last) begin
				count_q <= '0;
				emf_q   <= 1'b0;
				ps_q    <= 1'b0;
				esc_q   <= 1'b0;
			end else begin
				count_q <= status.count;
				emf_q   <= status.emf_seen;
				ps_q    <= status.ps_seen;
				esc_q   <= status.esc_seen;
			end
		end
	end

	// header and window need no clear: the count guards every read
	always_ff @(posedge clk) begin
		if (step) begin
			win_q <= win_n;
			hdr_q <= hdr_n;
		end
	end

endmodule

/* src/psfs_classify.sv */
// format decision and the result register on the master side
module psfs_classify (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  psfs_pkg::scan_status_t status,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [7:0]             m_axis_tdata
);
	import psfs_pkg::*;

	fmt_t code_q;
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (m_axis_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			code_q <= decide_fmt(status);
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {5'b0, code_q};

endmodule

/* src/print_stream_format_sniffer_core.sv */
// top level of the print stream format sniffer
// Usage:
//   s_axis carries one byte of a spooled print file per transfer; tlast marks
//   the final byte of a file. m_axis carries one format code per file, sent
//   on the transfer after the file's last byte is processed.
//   Codes: 0 unknown, 1 XPS, 2 PCL, 3 EMF, 4 PostScript, 5 RAW.
//   Only the first 8192 bytes of a file are scanned; later bytes are taken
//   and dropped, though their tlast still ends the file.
// Order: a byte is held in the input register and scanned as it leaves it;
//   a file's code goes into the m_axis result register as its last byte leaves.
// Throughput: one byte per cycle unless a last byte waits for the result slot;
//   the input register feeds the combinational window compare and state update.
// Reset: arst_n clears counters, flags and both valid bits; the first byte
//   after reset starts a new file. After each result the scan state clears.
// Stall: while a result waits on m_axis_tready, non-last bytes keep flowing;
//   a last byte waits in the input register until the result slot frees.
module print_stream_format_sniffer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // is_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [2:0] format_code, [7:3] zero
);
	import psfs_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         out_free;
	logic         advance;
	scan_status_t status;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	psfs_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.is_last   (last_s1),
		.status    (status)
	);

	psfs_classify u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && last_s1),
		.status        (status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
